@@ rtl/core/lcd_mode_timing_stat_irq_core_assert.svh @@
// Assertion macros used by the checker module of the LCD timing core.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef LCD_MODE_TIMING_STAT_IRQ_CORE_ASSERT_SVH
`define LCD_MODE_TIMING_STAT_IRQ_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define LMTSI_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lmtsi: same-cycle property violated");

// The consequence must hold in the cycle after the condition.
`define LMTSI_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lmtsi: next-cycle property violated");

`endif

@@ rtl/core/lmtsi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lmtsi_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int OAM_BYTES = 160;
    localparam int VRAM_AW = $clog2(VRAM_BYTES);
    localparam int OAM_AW = $clog2(OAM_BYTES);

    localparam int NUM_DISPLAY_REGS = 10;
    localparam int SLOT_W = 4;

    // Bus address ranges.
    localparam logic [15:0] VRAM_FIRST = 16'h8000;
    localparam logic [15:0] VRAM_LAST = 16'h9FFF;
    localparam logic [15:0] OAM_FIRST = 16'hFE00;
    localparam logic [15:0] OAM_LAST = 16'hFE9F;
    localparam logic [15:0] REG_FIRST = 16'hFF40;
    localparam logic [15:0] REG_LAST = 16'hFF4B;

    // Action codes carried in the input tuser.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Display register slots; the status and line registers live outside the slot array.
    localparam logic [SLOT_W-1:0] SLOT_LYC = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_LY = 4'd13;
    localparam logic [SLOT_W-1:0] SLOT_STAT = 4'd14;
    localparam logic [SLOT_W-1:0] SLOT_NONE = 4'd15;

    // Line timing in ticks.
    localparam logic [6:0] SCAN_TICKS = 7'd20;
    localparam logic [6:0] XFER_TICKS = 7'd43;
    localparam logic [6:0] HBLANK_TICKS = 7'd51;
    localparam logic [6:0] LINE_TICKS = 7'd114;
    localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
    localparam logic [7:0] LAST_LINE = 8'd153;

    // Status register bits.
    localparam logic [7:0] STAT_KEEP_MASK = 8'hF8;
    localparam int STAT_HBLANK_EN = 3;
    localparam int STAT_VBLANK_EN = 4;
    localparam int STAT_SCAN_EN = 5;
    localparam int STAT_LYC_EN = 6;

    // Mode codes as they appear on the result word and in the status register.
    localparam logic [1:0] MODE_CODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_CODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_CODE_SCAN = 2'd2;
    localparam logic [1:0] MODE_CODE_XFER = 2'd3;

    typedef enum logic [3:0] {
        M_HBLANK = 4'b0001,
        M_VBLANK = 4'b0010,
        M_SCAN   = 4'b0100,
        M_XFER   = 4'b1000
    } mode_t;

    // Input word, address in the low bits.
    typedef struct packed {
        logic [7:0]  write_data;
        logic [15:0] address;
    } in_word_t;

    // Result word, read data in the low bits.
    typedef struct packed {
        logic [7:0] current_line;
        logic [1:0] current_mode;
        logic       status_irq;
        logic       vblank_irq;
        logic       bad_address;
        logic [7:0] read_data;
    } out_word_t;

    localparam int IN_TDATA_W = 24;
    localparam int OUT_BITS = $bits(out_word_t);
    localparam int OUT_TDATA_W = 24;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            M_HBLANK: c = MODE_CODE_HBLANK;
            M_VBLANK: c = MODE_CODE_VBLANK;
            M_SCAN:   c = MODE_CODE_SCAN;
            M_XFER:   c = MODE_CODE_XFER;
            default:  c = MODE_CODE_SCAN;
        endcase
        return c;
    endfunction

    // Maps the offset from the first display register to a slot.
    function automatic logic [SLOT_W-1:0] reg_slot(input logic [3:0] offset);
        logic [SLOT_W-1:0] s;
        case (offset)
            4'd0:    s = 4'd0;
            4'd1:    s = SLOT_STAT;
            4'd2:    s = 4'd1;
            4'd3:    s = 4'd2;
            4'd4:    s = SLOT_LY;
            4'd5:    s = SLOT_LYC;
            4'd6:    s = 4'd4;
            4'd7:    s = 4'd5;
            4'd8:    s = 4'd6;
            4'd9:    s = 4'd7;
            4'd10:   s = 4'd8;
            4'd11:   s = 4'd9;
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lmtsi_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// The read data register only loads on a read, so it holds while the reader stalls.
module lmtsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lcd_mode_timing_stat_irq_core.sv @@
// An accepted word moves through stage one into the output register, which drives m_tdata.
// Throughput: one word per clock cycle, ticks and bus accesses alike, set by the
// single read port of each memory and the registered read path behind it, while no sweep
// runs and m_tready does not stall the output.
// Reset: asynchronous, active low. After reset the core sweeps both memories to zero,
// one address per cycle until every address is cleared; s_tready stays low during the sweep.
`timescale 1ns / 1ps
`default_nettype none

// LCD mode sequencer with status and vertical blanking interrupt pulses.
//
// Each input word is a tick, a bus read or a bus write. Ticks and accesses to the
// display registers are resolved in the cycle of acceptance against the register state.
// Video and object memory accesses go to two synchronous RAMs; their registered read data
// is merged into the result word in the second stage. Since only one word enters per
// cycle and writes land at the acceptance edge, a read always sees every earlier write,
// so no forwarding is needed.
//
// Pipeline: acceptance -> stage one (waits for RAM data) -> output register.
// The output register decouples the two sides, so a new word can enter while a finished
// result still waits for m_tready.
module lcd_mode_timing_stat_irq_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // Fields from the lowest bit: address[15:0], write_data[23:16].
    input  wire logic [lmtsi_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Fields from the lowest bit: action[1:0].
    input  wire logic [1:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // Fields from the lowest bit: read_data[7:0], bad_address[8], vblank_irq[9],
    // status_irq[10], current_mode[12:11], current_line[20:13], zero padding [23:21].
    output logic      [lmtsi_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    // ------------------------------------------------------------------
    // Register state
    // ------------------------------------------------------------------
    lmtsi_pkg::mode_t mode_reg, mode_next;
    logic [6:0]  countdown_reg, countdown_next;
    logic [7:0]  line_reg, line_next;
    logic [7:0]  stat_reg, stat_next;
    logic [2:0]  coin_reg, coin_next;     // bit 2 last compare match, bits 1..0 last mode
    logic        stat_line_reg, stat_line_next;
    logic [7:0]  dregs_reg [lmtsi_pkg::NUM_DISPLAY_REGS];
    logic [7:0]  dregs_next [lmtsi_pkg::NUM_DISPLAY_REGS];

    // Memory clearing sweep after reset.
    logic                          clr_active_reg, clr_active_next;
    logic [lmtsi_pkg::VRAM_AW-1:0] clr_addr_reg, clr_addr_next;

    // Stage one and the output register.
    logic                 s1_valid_reg, s1_valid_next;
    lmtsi_pkg::out_word_t s1_word_reg, s1_word_next;
    logic                 s1_vram_reg, s1_vram_next;
    logic                 s1_oam_reg, s1_oam_next;
    logic                 out_valid_reg, out_valid_next;
    lmtsi_pkg::out_word_t out_word_reg, out_word_next;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_free;
    logic accept;
    lmtsi_pkg::in_word_t in_word;

    assign in_word  = lmtsi_pkg::in_word_t'(s_tdata);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !clr_active_reg && (!s1_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(lmtsi_pkg::OUT_TDATA_W - lmtsi_pkg::OUT_BITS)'(0), out_word_reg};

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic                          vram_we, vram_re;
    logic [lmtsi_pkg::VRAM_AW-1:0] vram_waddr;
    logic [7:0]                    vram_wdata, vram_rdata;
    logic                          oam_we, oam_re;
    logic [lmtsi_pkg::OAM_AW-1:0]  oam_waddr;
    logic [7:0]                    oam_wdata, oam_rdata;

    lmtsi_ram #(
        .WIDTH (8),
        .DEPTH (lmtsi_pkg::VRAM_BYTES)
    ) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (vram_re),
        .raddr (in_word.address[lmtsi_pkg::VRAM_AW-1:0]),
        .rdata (vram_rdata)
    );

    lmtsi_ram #(
        .WIDTH (8),
        .DEPTH (lmtsi_pkg::OAM_BYTES)
    ) u_oam (
        .clk   (clk),
        .we    (oam_we),
        .waddr (oam_waddr),
        .wdata (oam_wdata),
        .re    (oam_re),
        .raddr (in_word.address[lmtsi_pkg::OAM_AW-1:0]),
        .rdata (oam_rdata)
    );

    // ------------------------------------------------------------------
    // Address decode
    // ------------------------------------------------------------------
    logic                        vram_hit, oam_hit, reg_hit;
    logic [lmtsi_pkg::SLOT_W-1:0] slot;

    assign vram_hit = in_word.address inside {[lmtsi_pkg::VRAM_FIRST:lmtsi_pkg::VRAM_LAST]};
    assign oam_hit  = in_word.address inside {[lmtsi_pkg::OAM_FIRST:lmtsi_pkg::OAM_LAST]};
    assign reg_hit  = in_word.address inside {[lmtsi_pkg::REG_FIRST:lmtsi_pkg::REG_LAST]};
    assign slot     = lmtsi_pkg::reg_slot(in_word.address[3:0]);

    // ------------------------------------------------------------------
    // Next-state logic for ticks and accesses
    // ------------------------------------------------------------------
    logic [7:0] rd_data;
    logic       bad, vbl, sirq;
    logic       match, line_up;
    logic [1:0] cur_code;
    logic [6:0] cd_load;

    always_comb
    begin
        mode_next      = mode_reg;
        countdown_next = countdown_reg;
        line_next      = line_reg;
        stat_next      = stat_reg;
        coin_next      = coin_reg;
        stat_line_next = stat_line_reg;
        dregs_next     = dregs_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next  = clr_addr_reg;

        rd_data = 8'd0;
        bad     = 1'b0;
        vbl     = 1'b0;
        sirq    = 1'b0;
        match   = 1'b0;
        line_up = 1'b0;
        cd_load = countdown_reg;
        cur_code = lmtsi_pkg::mode_code(mode_reg);

        vram_we    = 1'b0;
        vram_re    = 1'b0;
        vram_waddr = in_word.address[lmtsi_pkg::VRAM_AW-1:0];
        vram_wdata = in_word.write_data;
        oam_we     = 1'b0;
        oam_re     = 1'b0;
        oam_waddr  = in_word.address[lmtsi_pkg::OAM_AW-1:0];
        oam_wdata  = in_word.write_data;

        if (clr_active_reg)
        begin
            // Zero one video memory address per cycle, and the object memory address while it is in range.
            vram_we    = 1'b1;
            vram_waddr = clr_addr_reg;
            vram_wdata = 8'd0;
            oam_we     = clr_addr_reg < lmtsi_pkg::VRAM_AW'(lmtsi_pkg::OAM_BYTES);
            oam_waddr  = clr_addr_reg[lmtsi_pkg::OAM_AW-1:0];
            oam_wdata  = 8'd0;
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == lmtsi_pkg::VRAM_AW'(lmtsi_pkg::VRAM_BYTES - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
        else if (accept)
        begin
            case (s_tuser)
                lmtsi_pkg::ACT_TICK:
                begin
                    // Status line first, on the mode and line before this tick.
                    match = dregs_reg[lmtsi_pkg::SLOT_LYC] == line_reg;
                    if (coin_reg[1:0] != cur_code)
                    begin
                        case (mode_reg)
                            lmtsi_pkg::M_HBLANK: line_up = stat_reg[lmtsi_pkg::STAT_HBLANK_EN];
                            lmtsi_pkg::M_VBLANK: line_up = stat_reg[lmtsi_pkg::STAT_VBLANK_EN];
                            lmtsi_pkg::M_SCAN:   line_up = stat_reg[lmtsi_pkg::STAT_SCAN_EN];
                            default:             line_up = 1'b0;
                        endcase
                    end
                    if (match && stat_reg[lmtsi_pkg::STAT_LYC_EN] && !coin_reg[2])
                    begin
                        line_up = 1'b1;
                    end
                    sirq           = line_up && !stat_line_reg;
                    stat_line_next = line_up;
                    coin_next      = {match, cur_code};
                    stat_next      = (stat_reg & lmtsi_pkg::STAT_KEEP_MASK) | {5'd0, match, cur_code};

                    // Then the mode sequence.
                    if (countdown_reg == 7'd0)
                    begin
                        case (mode_reg)
                            lmtsi_pkg::M_SCAN:
                            begin
                                mode_next = lmtsi_pkg::M_XFER;
                                cd_load   = lmtsi_pkg::XFER_TICKS;
                            end
                            lmtsi_pkg::M_XFER:
                            begin
                                mode_next = lmtsi_pkg::M_HBLANK;
                                cd_load   = lmtsi_pkg::HBLANK_TICKS;
                            end
                            lmtsi_pkg::M_HBLANK:
                            begin
                                if (line_reg < lmtsi_pkg::LAST_VISIBLE_LINE)
                                begin
                                    mode_next = lmtsi_pkg::M_SCAN;
                                    cd_load   = lmtsi_pkg::SCAN_TICKS;
                                end
                                else
                                begin
                                    mode_next = lmtsi_pkg::M_VBLANK;
                                    cd_load   = lmtsi_pkg::LINE_TICKS;
                                    vbl       = 1'b1;
                                end
                                line_next = line_reg + 8'd1;
                            end
                            default:
                            begin
                                if (line_reg >= lmtsi_pkg::LAST_LINE)
                                begin
                                    mode_next = lmtsi_pkg::M_SCAN;
                                    cd_load   = lmtsi_pkg::SCAN_TICKS;
                                    line_next = 8'd0;
                                end
                                else
                                begin
                                    cd_load   = lmtsi_pkg::LINE_TICKS;
                                    line_next = line_reg + 8'd1;
                                end
                            end
                        endcase
                    end
                    countdown_next = cd_load - 7'd1;
                end
                lmtsi_pkg::ACT_READ, lmtsi_pkg::ACT_WRITE:
                begin
                    if (vram_hit)
                    begin
                        vram_we = s_tuser == lmtsi_pkg::ACT_WRITE;
                        vram_re = s_tuser == lmtsi_pkg::ACT_READ;
                    end
                    else if (oam_hit)
                    begin
                        oam_we = s_tuser == lmtsi_pkg::ACT_WRITE;
                        oam_re = s_tuser == lmtsi_pkg::ACT_READ;
                    end
                    else if (reg_hit)
                    begin
                        if (s_tuser == lmtsi_pkg::ACT_WRITE)
                        begin
                            // A write to the line counter is dropped.
                            if (slot == lmtsi_pkg::SLOT_STAT)
                            begin
                                stat_next = in_word.write_data;
                            end
                            else if (slot < lmtsi_pkg::SLOT_W'(lmtsi_pkg::NUM_DISPLAY_REGS))
                            begin
                                dregs_next[slot] = in_word.write_data;
                            end
                        end
                        else
                        begin
                            if (slot == lmtsi_pkg::SLOT_STAT)
                            begin
                                rd_data = stat_reg;
                            end
                            else if (slot == lmtsi_pkg::SLOT_LY)
                            begin
                                rd_data = line_reg;
                            end
                            else if (slot < lmtsi_pkg::SLOT_W'(lmtsi_pkg::NUM_DISPLAY_REGS))
                            begin
                                rd_data = dregs_reg[slot];
                            end
                        end
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                default:
                begin
                    // An unknown action changes nothing.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline stages
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_word_next = s1_word_reg;
        s1_vram_next = s1_vram_reg;
        s1_oam_next  = s1_oam_reg;
        if (accept)
        begin
            s1_valid_next             = 1'b1;
            s1_word_next.read_data    = rd_data;
            s1_word_next.bad_address  = bad;
            s1_word_next.vblank_irq   = vbl;
            s1_word_next.status_irq   = sirq;
            s1_word_next.current_mode = lmtsi_pkg::mode_code(mode_next);
            s1_word_next.current_line = line_next;
            s1_vram_next              = vram_re;
            s1_oam_next               = oam_re;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
            out_word_next  = s1_word_reg;
            if (s1_vram_reg)
            begin
                out_word_next.read_data = vram_rdata;
            end
            else if (s1_oam_reg)
            begin
                out_word_next.read_data = oam_rdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lmtsi_pkg::M_SCAN;
            countdown_reg  <= 7'd0;
            line_reg       <= 8'd0;
            stat_reg       <= 8'd0;
            coin_reg       <= 3'd0;
            stat_line_reg  <= 1'b0;
            for (int i = 0; i < lmtsi_pkg::NUM_DISPLAY_REGS; i++)
            begin
                dregs_reg[i] <= 8'd0;
            end
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            countdown_reg  <= countdown_next;
            line_reg       <= line_next;
            stat_reg       <= stat_next;
            coin_reg       <= coin_next;
            stat_line_reg  <= stat_line_next;
            dregs_reg      <= dregs_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg  <= s1_word_next;
        s1_vram_reg  <= s1_vram_next;
        s1_oam_reg   <= s1_oam_next;
        out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/lmtsi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "lcd_mode_timing_stat_irq_core_assert.svh"

// Port-level checks on the result stream of the LCD timing core.
module lmtsi_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [lmtsi_pkg::OUT_TDATA_W-1:0] m_tdata
);

    lmtsi_pkg::out_word_t w;

    assign w = lmtsi_pkg::out_word_t'(m_tdata[lmtsi_pkg::OUT_BITS-1:0]);

    // A stalled result word holds.
    `LMTSI_ASSERT_NXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The vblank pulse comes with the first blanking line.
    `LMTSI_ASSERT_IMP(a_vblank_entry, clk, rst_n, m_tvalid && w.vblank_irq, w.current_mode == lmtsi_pkg::MODE_CODE_VBLANK && w.current_line == lmtsi_pkg::LAST_VISIBLE_LINE + 8'd1)

    // A failed decode returns nothing else.
    `LMTSI_ASSERT_IMP(a_bad_quiet, clk, rst_n, m_tvalid && w.bad_address, w.read_data == 8'd0 && !w.vblank_irq && !w.status_irq)

    // Lines past the visible area are always in vertical blanking and never beyond the last line.
    `LMTSI_ASSERT_IMP(a_blank_lines, clk, rst_n, m_tvalid && w.current_line > lmtsi_pkg::LAST_VISIBLE_LINE, w.current_mode == lmtsi_pkg::MODE_CODE_VBLANK && w.current_line <= lmtsi_pkg::LAST_LINE)

endmodule

bind lcd_mode_timing_stat_irq_core lmtsi_checker u_lmtsi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/lcd_mode_timing_stat_irq_core_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the LCD mode sequencer. Bus words go in through the
// slave stream and one result word per input comes out of the master stream.
// A shadow copy of the display state runs alongside the core. It is advanced
// once for every input word the core accepts, and every result that leaves the
// core is compared field by field with the oldest shadow result still waiting.
module lcd_mode_timing_stat_irq_core_tb;

    import lmtsi_pkg::*;

    // Action code the core must ignore; the package only names the three real ones.
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    // Offsets of the display registers from the first register address.
    localparam logic [3:0] OFF_LCDC = 4'd0;
    localparam logic [3:0] OFF_STAT = 4'd1;
    localparam logic [3:0] OFF_LY   = 4'd4;
    localparam logic [3:0] OFF_LYC  = 4'd5;
    localparam logic [3:0] OFF_WX   = 4'd11;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 40;
    localparam int MIXED_WORDS    = 200;
    localparam int FRAME_WORDS    = 190;

    // One bus word as the testbench keeps it before it is sent.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } bus_word_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = ACT_TICK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    lcd_mode_timing_stat_irq_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Words waiting to be sent, and the results the shadow state expects back.
    bus_word_t bus_word_q[$];
    out_word_t expected_lcd_words[$];

    // Handshake pacing, changed between phases by the stimulus and hold-off processes.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        holdoff_go   = 1'b0;
    logic        rx_hold      = 1'b0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_count   = 0;
    int unsigned vblank_seen    = 0;
    int unsigned status_seen    = 0;
    int unsigned bad_seen       = 0;
    int unsigned accepted_by_action[4];

    // Shadow copy of the core state. The display registers are kept in a
    // sixteen-entry array indexed by the address offset; the status and line
    // registers have their own variables and their entries stay unused.
    logic [7:0] vram_copy [VRAM_BYTES];
    logic [7:0] oam_copy  [OAM_BYTES];
    logic [7:0] lcd_regs  [16];
    logic [1:0] lcd_mode;
    logic [6:0] ticks_left;
    logic [7:0] lcd_line;
    logic [7:0] stat_reg;
    logic [2:0] stat_seen;   // {compare hit on the last tick, mode on the last tick}
    logic       stat_line;

    task automatic clear_lcd_state();
        foreach (vram_copy[i]) vram_copy[i] = 8'h00;
        foreach (oam_copy[i]) oam_copy[i] = 8'h00;
        foreach (lcd_regs[i]) lcd_regs[i] = 8'h00;
        lcd_mode   = MODE_CODE_SCAN;
        ticks_left = 7'd0;
        lcd_line   = 8'd0;
        stat_reg   = 8'h00;
        stat_seen  = 3'd0;
        stat_line  = 1'b0;
    endtask

    // Applies one accepted bus word to the shadow state and returns the result
    // word the core has to produce for it.
    function automatic out_word_t lcd_step(input bus_word_t w);
        out_word_t  res;
        logic       lyc_hit;
        logic       line_up;
        logic       decoded;
        logic       is_write;
        logic [3:0] off;
        res      = '0;
        off      = w.address[3:0];
        is_write = (w.action == ACT_WRITE);
        if (w.action == ACT_TICK) begin
            // The status line is evaluated against the mode and line left by the
            // previous tick, before the sequencer moves on.
            lyc_hit = (lcd_regs[OFF_LYC] == lcd_line);
            line_up = 1'b0;
            if (stat_seen[1:0] != lcd_mode && lcd_mode != MODE_CODE_XFER
                && stat_reg[STAT_HBLANK_EN + lcd_mode])
                line_up = 1'b1;
            if (lyc_hit && stat_reg[STAT_LYC_EN] && !stat_seen[2])
                line_up = 1'b1;
            res.status_irq = line_up && !stat_line;
            stat_line = line_up;
            stat_seen = {lyc_hit, lcd_mode};
            stat_reg  = (stat_reg & STAT_KEEP_MASK) | {5'b00000, stat_seen};

            if (ticks_left == 7'd0) begin
                case (lcd_mode)
                    MODE_CODE_SCAN:
                    begin
                        lcd_mode   = MODE_CODE_XFER;
                        ticks_left = XFER_TICKS;
                    end
                    MODE_CODE_XFER:
                    begin
                        lcd_mode   = MODE_CODE_HBLANK;
                        ticks_left = HBLANK_TICKS;
                    end
                    MODE_CODE_HBLANK:
                    begin
                        if (lcd_line < LAST_VISIBLE_LINE) begin
                            lcd_mode   = MODE_CODE_SCAN;
                            ticks_left = SCAN_TICKS;
                        end
                        else
                        begin
                            lcd_mode       = MODE_CODE_VBLANK;
                            ticks_left     = LINE_TICKS;
                            res.vblank_irq = 1'b1;
                        end
                        lcd_line = lcd_line + 8'd1;
                    end
                    default:
                    begin
                        // Vertical blanking: count lines, wrap after the last one.
                        if (lcd_line >= LAST_LINE) begin
                            lcd_mode   = MODE_CODE_SCAN;
                            ticks_left = SCAN_TICKS;
                            lcd_line   = 8'd0;
                        end
                        else
                        begin
                            ticks_left = LINE_TICKS;
                            lcd_line   = lcd_line + 8'd1;
                        end
                    end
                endcase
            end
            // The countdown always steps, so a fresh load of N lasts N ticks.
            ticks_left = ticks_left - 7'd1;
        end
        else if (w.action == ACT_READ || is_write) begin
            decoded = 1'b1;
            if (w.address >= VRAM_FIRST && w.address <= VRAM_LAST) begin
                if (is_write) vram_copy[w.address[12:0]] = w.write_data;
                else res.read_data = vram_copy[w.address[12:0]];
            end
            else if (w.address >= OAM_FIRST && w.address <= OAM_LAST) begin
                if (is_write) oam_copy[w.address[7:0]] = w.write_data;
                else res.read_data = oam_copy[w.address[7:0]];
            end
            else if (w.address >= REG_FIRST && w.address <= REG_LAST) begin
                if (off == OFF_STAT) begin
                    // All eight bits land; the next tick rewrites the low three.
                    if (is_write) stat_reg = w.write_data;
                    else res.read_data = stat_reg;
                end
                else if (off == OFF_LY) begin
                    // The line counter is read-only; writes are dropped.
                    if (!is_write) res.read_data = lcd_line;
                end
                else
                begin
                    if (is_write) lcd_regs[off] = w.write_data;
                    else res.read_data = lcd_regs[off];
                end
            end
            else
            begin
                decoded = 1'b0;
            end
            res.bad_address = !decoded;
        end
        // Any other action code leaves the state alone and reports nothing.
        res.current_mode = lcd_mode;
        res.current_line = lcd_line;
        return res;
    endfunction

    task automatic queue_word(input logic [1:0] act, input logic [15:0] addr,
                              input logic [7:0] data);
        bus_word_q.push_back(bus_word_t'{act, addr, data});
    endtask

    // Addresses weighted toward the decoded windows, with a small video memory
    // window so reads often return earlier writes, addresses just outside every window,
    // and fully random addresses so that every address bit toggles.
    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        case ($urandom_range(0, 9))
            0, 1:    a = VRAM_FIRST + 16'($urandom_range(0, 31));
            2:       a = 16'($urandom_range(VRAM_FIRST, VRAM_LAST));
            3, 4:    a = 16'($urandom_range(OAM_FIRST, OAM_LAST));
            5, 6, 7: a = 16'($urandom_range(REG_FIRST, REG_LAST));
            8:
            begin
                case ($urandom_range(0, 5))
                    0:       a = VRAM_FIRST - 16'd1;
                    1:       a = VRAM_LAST + 16'd1;
                    2:       a = OAM_FIRST - 16'd1;
                    3:       a = OAM_LAST + 16'd1;
                    4:       a = REG_FIRST - 16'd1;
                    default: a = REG_LAST + 16'd1;
                endcase
            end
            default: a = 16'($urandom());
        endcase
        return a;
    endfunction

    function automatic bus_word_t mixed_word();
        bus_word_t   w;
        int unsigned roll;
        roll         = $urandom_range(0, 99);
        w.address    = pick_address();
        w.write_data = 8'($urandom());
        if (roll < 35) w.action = ACT_TICK;
        else if (roll < 65) w.action = ACT_READ;
        else if (roll < 96) w.action = ACT_WRITE;
        else w.action = ACT_IGNORED;
        // Compare values near the current line make coincidence hits likely.
        if (w.action == ACT_WRITE && w.address == REG_FIRST + 16'(OFF_LYC)
            && roll[0])
            w.write_data = lcd_line + 8'($urandom_range(0, 2));
        return w;
    endfunction

    // Mostly ticks, so the sequencer steps through its modes and lines, with the
    // compare and status registers reprogrammed now and then to provoke status
    // interrupts.
    function automatic bus_word_t frame_word();
        bus_word_t   w;
        int unsigned roll;
        roll = $urandom_range(0, 999);
        w    = bus_word_t'{ACT_TICK, 16'($urandom()), 8'($urandom())};
        if (roll < 950) begin
            w.action = ACT_TICK;
        end
        else if (roll < 965) begin
            w = bus_word_t'{ACT_WRITE, REG_FIRST + 16'(OFF_LYC),
                            8'($urandom_range(0, LAST_LINE))};
        end
        else if (roll < 975) begin
            w.action  = ACT_WRITE;
            w.address = REG_FIRST + 16'(OFF_STAT);
        end
        else if (roll < 990) begin
            w.action = ACT_READ;
            case ($urandom_range(0, 2))
                0:       w.address = REG_FIRST + 16'(OFF_STAT);
                1:       w.address = REG_FIRST + 16'(OFF_LY);
                default: w.address = REG_FIRST + 16'(OFF_LYC);
            endcase
        end
        else
        begin
            w = mixed_word();
        end
        return w;
    endfunction

    // Sender. A word stays on the bus until it is taken; the shadow state is
    // advanced at the very edge where the core accepts it.
    bus_word_t on_bus;

    always @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            expected_lcd_words.push_back(lcd_step(on_bus));
            accepted_by_action[on_bus.action]++;
        end
        if (!s_tvalid || s_tready) begin
            if (bus_word_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                on_bus   = bus_word_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {on_bus.write_data, on_bus.address};
                s_tuser  <= on_bus.action;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing and the
    // core's input eventually backs up.
    initial begin : rx_holdoff
        wait (holdoff_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic report_mismatch(input string field_name, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t: result %0d, %s is 0x%0h, expected 0x%0h",
                     $time, result_count, field_name, got, want);
    endtask

    // Receiver and checker.
    out_word_t got_word;
    out_word_t want_word;

    always @(posedge clk) begin
        m_tready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) >= rx_stall_pct);
        if (rst_n && m_tvalid && m_tready) begin
            result_count++;
            got_word = out_word_t'(m_tdata[OUT_BITS-1:0]);
            if (m_tdata[OUT_TDATA_W-1:OUT_BITS] !== '0)
                report_mismatch("padding", m_tdata[OUT_TDATA_W-1:OUT_BITS], 0);
            if (expected_lcd_words.size() == 0) begin
                report_mismatch("word with nothing pending", m_tdata, 0);
            end
            else
            begin
                want_word = expected_lcd_words.pop_front();
                if (got_word.read_data !== want_word.read_data)
                    report_mismatch("read_data", got_word.read_data, want_word.read_data);
                if (got_word.bad_address !== want_word.bad_address)
                    report_mismatch("bad_address", got_word.bad_address,
                                    want_word.bad_address);
                if (got_word.vblank_irq !== want_word.vblank_irq)
                    report_mismatch("vblank_irq", got_word.vblank_irq, want_word.vblank_irq);
                if (got_word.status_irq !== want_word.status_irq)
                    report_mismatch("status_irq", got_word.status_irq, want_word.status_irq);
                if (got_word.current_mode !== want_word.current_mode)
                    report_mismatch("current_mode", got_word.current_mode,
                                    want_word.current_mode);
                if (got_word.current_line !== want_word.current_line)
                    report_mismatch("current_line", got_word.current_line,
                                    want_word.current_line);
                vblank_seen += want_word.vblank_irq;
                status_seen += want_word.status_irq;
                bad_seen    += want_word.bad_address;
            end
        end
    end

    // Watchdog. The budget covers the memory sweep after reset plus the slowest
    // pacing phase many times over.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_lcd_words.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Waits until nothing is queued or offered and every outstanding result has come back.
    task automatic wait_for_drain();
        while (bus_word_q.size() != 0 || s_tvalid || expected_lcd_words.size() != 0)
            @(negedge clk);
    endtask

    initial begin : stimulus
        int n;
        clear_lcd_state();
        foreach (accepted_by_action[i]) accepted_by_action[i] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words. The core is still sweeping its memories, so these
        // simply wait for s_tready to come up.
        // First tick after reset: the countdown is zero, so object scan ends at once.
        queue_word(ACT_TICK, 16'h0000, 8'h00);
        // Memory windows at both ends, read back after writing.
        queue_word(ACT_READ, VRAM_FIRST, 8'h00);
        queue_word(ACT_WRITE, VRAM_FIRST, 8'hFF);
        queue_word(ACT_READ, VRAM_FIRST, 8'h00);
        queue_word(ACT_WRITE, VRAM_LAST, 8'hA5);
        queue_word(ACT_READ, VRAM_LAST, 8'hFF);
        queue_word(ACT_WRITE, OAM_FIRST, 8'h01);
        queue_word(ACT_READ, OAM_FIRST, 8'h00);
        queue_word(ACT_WRITE, OAM_LAST, 8'h80);
        queue_word(ACT_READ, OAM_LAST, 8'h00);
        // Addresses just outside every window, and the top of the bus.
        queue_word(ACT_READ, OAM_LAST + 16'd1, 8'h00);
        queue_word(ACT_WRITE, VRAM_FIRST - 16'd1, 8'hFF);
        queue_word(ACT_READ, VRAM_LAST + 16'd1, 8'h00);
        queue_word(ACT_READ, REG_FIRST - 16'd1, 8'h00);
        queue_word(ACT_WRITE, REG_LAST + 16'd1, 8'h5A);
        queue_word(ACT_READ, 16'hFFFF, 8'h00);
        // A write to the line counter is accepted but has no effect.
        queue_word(ACT_WRITE, REG_FIRST + 16'(OFF_LY), 8'h55);
        queue_word(ACT_READ, REG_FIRST + 16'(OFF_LY), 8'h00);
        // Status write keeps all bits until the next tick refreshes the low three;
        // with every enable set the mode changes raise the status line.
        queue_word(ACT_WRITE, REG_FIRST + 16'(OFF_STAT), 8'hFF);
        queue_word(ACT_READ, REG_FIRST + 16'(OFF_STAT), 8'h00);
        queue_word(ACT_TICK, 16'hFFFF, 8'hFF);
        queue_word(ACT_READ, REG_FIRST + 16'(OFF_STAT), 8'h00);
        queue_word(ACT_WRITE, REG_FIRST + 16'(OFF_WX), 8'hFF);
        queue_word(ACT_READ, REG_FIRST + 16'(OFF_WX), 8'h00);
        // An undefined action code must leave everything untouched.
        queue_word(ACT_IGNORED, 16'hFFFF, 8'hFF);
        wait_for_drain();

        // Back-to-back traffic, then a tick-heavy run so the sequencer moves
        // through several mode changes and lines.
        for (n = 0; n < MIXED_WORDS; n++) bus_word_q.push_back(mixed_word());
        for (n = 0; n < FRAME_WORDS; n++) bus_word_q.push_back(frame_word());
        wait_for_drain();

        // Sender leaves gaps.
        tx_idle_pct = 55;
        for (n = 0; n < MIXED_WORDS; n++) bus_word_q.push_back(mixed_word());
        wait_for_drain();

        // Receiver stalls, including one long hold-off while the sender keeps
        // offering words until the core stops taking them.
        tx_idle_pct  = 0;
        rx_stall_pct = 55;
        for (n = 0; n < MIXED_WORDS; n++) bus_word_q.push_back(mixed_word());
        holdoff_go = 1'b1;
        wait_for_drain();

        // Both sides irregular, with another tick-heavy run.
        tx_idle_pct  = 37;
        rx_stall_pct = 37;
        for (n = 0; n < MIXED_WORDS; n++) bus_word_q.push_back(mixed_word());
        for (n = 0; n < FRAME_WORDS; n++) bus_word_q.push_back(frame_word());
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d ticks, %0d reads, %0d writes and %0d ignored words; %0d hit no window.",
                 accepted_by_action[ACT_TICK], accepted_by_action[ACT_READ],
                 accepted_by_action[ACT_WRITE], accepted_by_action[ACT_IGNORED], bad_seen);
        $display("Checked %0d results with %0d vblank and %0d status pulses, %0d mismatches.",
                 result_count, vblank_seen, status_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lmtsi_pkg.sv
rtl/core/lmtsi_ram.sv
rtl/core/lcd_mode_timing_stat_irq_core.sv
rtl/core/lmtsi_checker.sv
verif/lcd_mode_timing_stat_irq_core_tb.sv
